>>> sv/bbhe_pkg.sv
// ----------------------------------------------------------------------------
// bbhe_pkg
// Shared types, register indexes and helper functions of the bicubic Bezier
// height evaluator.
// ----------------------------------------------------------------------------
package bbhe_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_RESOLUTION = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATCH_WIDTH     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATCH_DEPTH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_ROW_0      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_ROW_1      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_ROW_2      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_ROW_3      = 3'd6;

    localparam int RES_W     = 9;
    localparam int DIVIDEND_W = 24;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES = DIVIDEND_W / DIV_BITS_PER_STAGE;

    typedef struct packed {
        logic [7:0] row_index;
        logic [7:0] col_index;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] x_position;
        logic signed [15:0] height_value;
        logic signed [15:0] z_position;
    } out_item_t;

    typedef struct packed {
        logic [RES_W-1:0]      rem;
        logic [DIVIDEND_W-1:0] num;
        logic [DIVIDEND_W-1:0] quo;
    } div_state_t;

    function automatic div_state_t div_step(div_state_t st, logic [RES_W-1:0] d);
        div_state_t r;
        logic [RES_W:0] t;
        r = st;
        for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
            t = {r.rem, r.num[DIVIDEND_W-1]};
            r.num = {r.num[DIVIDEND_W-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                r.rem = RES_W'(t - {1'b0, d});
                r.quo = {r.quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r.rem = t[RES_W-1:0];
                r.quo = {r.quo[DIVIDEND_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7fff;
        end else if (v < -64'sd32768) begin
            return -16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

>>> sv/bbhe_div.sv
// ----------------------------------------------------------------------------
// bbhe_div
// Pipelined restoring divider, four quotient bits per stage.
// ----------------------------------------------------------------------------
module bbhe_div (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [bbhe_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [bbhe_pkg::RES_W-1:0]          divisor,
    output logic [bbhe_pkg::DIVIDEND_W-1:0]     quotient
);

    bbhe_pkg::div_state_t st_reg [bbhe_pkg::DIV_STAGES];
    bbhe_pkg::div_state_t st_in;

    assign st_in = '{rem: '0, num: dividend, quo: '0};

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= bbhe_pkg::div_step(st_in, divisor);
            for (int k = 1; k < bbhe_pkg::DIV_STAGES; k++) begin
                st_reg[k] <= bbhe_pkg::div_step(st_reg[k-1], divisor);
            end
        end
    end

    assign quotient = st_reg[bbhe_pkg::DIV_STAGES-1].quo;

endmodule

>>> sv/bicubic_bezier_height_eval.sv
// ----------------------------------------------------------------------------
// bicubic_bezier_height_eval
// Grid point to (x, height, z) evaluator for a bicubic Bezier height patch.
// ----------------------------------------------------------------------------
// One grid point enters per cycle while the output is not stalled. Each point
// passes an input stage, the six stages of the four-bit-per-stage dividers for
// u, v, x and z, and then seven multiply and sum stages. A stall at the output
// holds the whole pipeline. Configuration is taken at once from the write port.
// ----------------------------------------------------------------------------
module bicubic_bezier_height_eval #(
    parameter int MAX_RESOLUTION = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bbhe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bbhe_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bbhe_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bbhe_pkg::out_item_t                 m_item
);

    localparam int RES_W = bbhe_pkg::RES_W;
    localparam int DW    = bbhe_pkg::DIVIDEND_W;
    localparam int NST   = 1 + bbhe_pkg::DIV_STAGES + 7;
    localparam logic [RES_W-1:0] MAX_RES_CLIP =
        (MAX_RESOLUTION > (1 << RES_W) - 1) ? {RES_W{1'b1}} : RES_W'(MAX_RESOLUTION);
    localparam logic [50:0] HALF = 51'h8000_0000;

    logic [RES_W-1:0] res_reg;
    logic [15:0]      width_reg;
    logic [15:0]      depth_reg;
    logic [63:0]      ctrl_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg     <= RES_W'(16);
            width_reg   <= 16'd256;
            depth_reg   <= 16'd256;
            ctrl_reg[0] <= '0;
            ctrl_reg[1] <= '0;
            ctrl_reg[2] <= '0;
            ctrl_reg[3] <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bbhe_pkg::REG_GRID_RESOLUTION: res_reg     <= cfg_wr_data[RES_W-1:0];
                bbhe_pkg::REG_PATCH_WIDTH:     width_reg   <= cfg_wr_data[15:0];
                bbhe_pkg::REG_PATCH_DEPTH:     depth_reg   <= cfg_wr_data[15:0];
                bbhe_pkg::REG_CTRL_ROW_0:      ctrl_reg[0] <= cfg_wr_data;
                bbhe_pkg::REG_CTRL_ROW_1:      ctrl_reg[1] <= cfg_wr_data;
                bbhe_pkg::REG_CTRL_ROW_2:      ctrl_reg[2] <= cfg_wr_data;
                bbhe_pkg::REG_CTRL_ROW_3:      ctrl_reg[3] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic [RES_W-1:0] res_eff;
    always_comb begin
        if (res_reg == '0) begin
            res_eff = RES_W'(1);
        end else if (int'(res_reg) > MAX_RESOLUTION) begin
            res_eff = MAX_RES_CLIP;
        end else begin
            res_eff = res_reg;
        end
    end

    logic adv;
    logic [NST-1:0] vld_reg;
    assign adv     = !vld_reg[NST-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // stage 0: clamp indexes, form dividends
    logic [7:0]    i_c, j_c;
    logic [DW-1:0] ud_reg, vd_reg, xd_reg, zd_reg;

    assign i_c = ({1'b0, s_item.row_index} > res_eff) ? res_eff[7:0] : s_item.row_index;
    assign j_c = ({1'b0, s_item.col_index} > res_eff) ? res_eff[7:0] : s_item.col_index;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ud_reg <= {i_c, 16'h0};
            vd_reg <= {j_c, 16'h0};
            xd_reg <= DW'(i_c) * DW'(width_reg);
            zd_reg <= DW'(j_c) * DW'(depth_reg);
        end
    end

    logic [DW-1:0] uq, vq, xq, zq;

    bbhe_div u_div_u (.aclk(aclk), .en(adv), .dividend(ud_reg), .divisor(res_eff), .quotient(uq));
    bbhe_div u_div_v (.aclk(aclk), .en(adv), .dividend(vd_reg), .divisor(res_eff), .quotient(vq));
    bbhe_div u_div_x (.aclk(aclk), .en(adv), .dividend(xd_reg), .divisor(res_eff), .quotient(xq));
    bbhe_div u_div_z (.aclk(aclk), .en(adv), .dividend(zd_reg), .divisor(res_eff), .quotient(zq));

    // P1: squares, placement
    logic [16:0] u1, v1, su1, sv1;
    logic [16:0] u_reg, v_reg, su_reg, sv_reg;
    logic [33:0] uu_reg, vv_reg, ss_u_reg, ss_v_reg;
    logic signed [24:0] xdiff, zdiff;
    logic signed [15:0] xpos_reg [7];
    logic signed [15:0] zpos_reg [7];

    assign u1  = uq[16:0];
    assign v1  = vq[16:0];
    assign su1 = 17'h10000 - u1;
    assign sv1 = 17'h10000 - v1;
    assign xdiff = signed'({1'b0, xq}) - signed'({10'b0, width_reg[15:1]});
    assign zdiff = signed'({1'b0, zq}) - signed'({10'b0, depth_reg[15:1]});

    always_ff @(posedge aclk) begin
        if (adv) begin
            u_reg       <= u1;
            v_reg       <= v1;
            su_reg      <= su1;
            sv_reg      <= sv1;
            uu_reg      <= 34'(u1) * 34'(u1);
            vv_reg      <= 34'(v1) * 34'(v1);
            ss_u_reg    <= 34'(su1) * 34'(su1);
            ss_v_reg    <= 34'(sv1) * 34'(sv1);
            xpos_reg[0] <= bbhe_pkg::sat16(64'(xdiff));
            zpos_reg[0] <= bbhe_pkg::sat16(64'(zdiff));
            for (int k = 1; k < 7; k++) begin
                xpos_reg[k] <= xpos_reg[k-1];
                zpos_reg[k] <= zpos_reg[k-1];
            end
        end
    end

    // P2: cubic terms
    logic [50:0] cu_reg [4];
    logic [50:0] cv_reg [4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            cu_reg[0] <= 51'(ss_u_reg) * 51'(su_reg);
            cu_reg[1] <= 51'(ss_u_reg) * 51'(u_reg);
            cu_reg[2] <= 51'(uu_reg) * 51'(su_reg);
            cu_reg[3] <= 51'(uu_reg) * 51'(u_reg);
            cv_reg[0] <= 51'(ss_v_reg) * 51'(sv_reg);
            cv_reg[1] <= 51'(ss_v_reg) * 51'(v_reg);
            cv_reg[2] <= 51'(vv_reg) * 51'(sv_reg);
            cv_reg[3] <= 51'(vv_reg) * 51'(v_reg);
        end
    end

    // P3: rounded basis weights
    logic [16:0] wu_reg [3][4];
    logic [16:0] wv_reg [4];
    logic [50:0] tu [4];
    logic [50:0] tv [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (k == 1 || k == 2) begin
                tu[k] = 51'(3) * cu_reg[k] + HALF;
                tv[k] = 51'(3) * cv_reg[k] + HALF;
            end else begin
                tu[k] = cu_reg[k] + HALF;
                tv[k] = cv_reg[k] + HALF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                wu_reg[0][k] <= tu[k][48:32];
                wv_reg[k]    <= tv[k][48:32];
                wu_reg[1][k] <= wu_reg[0][k];
                wu_reg[2][k] <= wu_reg[1][k];
            end
        end
    end

    // P4: v weights times control heights
    logic signed [33:0] prod_reg [4][4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 4; a++) begin
                for (int b = 0; b < 4; b++) begin
                    prod_reg[a][b] <= 34'(signed'({1'b0, wv_reg[b]}))
                                      * 34'(signed'(ctrl_reg[a][16*b +: 16]));
                end
            end
        end
    end

    // P5: row sums
    logic signed [35:0] row_reg [4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 4; a++) begin
                row_reg[a] <= 36'(prod_reg[a][0]) + 36'(prod_reg[a][1])
                            + 36'(prod_reg[a][2]) + 36'(prod_reg[a][3]);
            end
        end
    end

    // P6: u weights times row sums
    logic signed [53:0] term_reg [4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 4; a++) begin
                term_reg[a] <= 54'(signed'({1'b0, wu_reg[2][a]})) * 54'(row_reg[a]);
            end
        end
    end

    // P7: accumulate, round, saturate
    logic signed [63:0] acc;
    logic signed [63:0] yshift;
    logic signed [15:0] y_reg;

    assign acc    = 64'(term_reg[0]) + 64'(term_reg[1]) + 64'(term_reg[2])
                  + 64'(term_reg[3]) + 64'sh8000_0000;
    assign yshift = acc >>> 32;

    always_ff @(posedge aclk) begin
        if (adv) begin
            y_reg <= bbhe_pkg::sat16(yshift);
        end
    end

    assign m_item.x_position   = xpos_reg[6];
    assign m_item.height_value = y_reg;
    assign m_item.z_position   = zpos_reg[6];

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("item taken while output stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("stalled result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_eff != '0)
        else $error("zero divisor");

endmodule
